// ===== src/clt_pkg.sv =====
// clt_pkg: beat types and character constants for the command line tokenizer
// no dependencies
package clt_pkg;

	typedef struct packed {
		logic       action;
		logic [7:0] char_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] repeat_count;
		logic       token_end;
		logic       unterminated;
		logic       run_overflow;
		logic       last;
	} out_beat_t;

	localparam logic       ACT_BYTE = 1'b0;
	localparam logic       ACT_END  = 1'b1;

	localparam logic       MODE_GNU = 1'b0;
	localparam logic       MODE_WIN = 1'b1;

	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam int unsigned REG_SYNTAX_MODE = 0;

endpackage

// ===== src/command_line_tokenizer_top.sv =====
// command line tokenizer: splits a byte stream into argument tokens, gnu or windows rules
// input register, single-pass token logic, four-entry result queue, apb mode register
// depends on clt_pkg
// a byte accepted into the input register passes the token step into the result queue
// throughput: one byte per cycle while the result queue has room; a byte may give two result beats,
//   the four-entry result queue stalls input only when it cannot take two more beats
// reset: arst_n clears mode, line state, overflow flag, input stage and result queue
module command_line_tokenizer_top #(
	parameter int unsigned MAX_BACKSLASH_RUN = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  clt_pkg::in_beat_t  byte_beat,
	output logic              tok_valid,
	input  logic              tok_stall,
	output clt_pkg::out_beat_t tok_beat,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import clt_pkg::*;

	localparam logic [7:0] RUN_LIMIT = (MAX_BACKSLASH_RUN > 255) ? 8'd255
		: MAX_BACKSLASH_RUN[7:0];
	localparam int unsigned QDEPTH = 4;

	// configuration
	logic mode_q;
	logic cfg_wr;

	// line state
	logic       inside_q, dq_q, sq_q, esc_q, cqp_q, ovf_q;
	logic [7:0] run_q;
	logic       nx_inside, nx_dq, nx_sq, nx_esc, nx_cqp, nx_ovf;
	logic [7:0] nx_run;

	// input stage
	in_beat_t beat_s1;
	logic     valid_s1;
	logic     fire;

	// step results
	out_beat_t res [2];
	logic [1:0] n_res;
	logic       done;
	logic [7:0] c;

	// result queue
	out_beat_t q_q [QDEPTH];
	logic [1:0] head_q, tail_q;
	logic [2:0] cnt_q, cnt_after;
	logic       pop;

	function automatic logic is_space(input logic [7:0] ch);
		return ch == CH_SP || ch == CH_TAB || ch == CH_LF || ch == CH_CR;
	endfunction

	function automatic out_beat_t mk(input logic [7:0] b, input logic [7:0] cnt,
		input logic e, input logic u);
		out_beat_t r;
		r = '0;
		r.out_byte     = (cnt != 8'd0) ? b : 8'd0;
		r.repeat_count = cnt;
		r.token_end    = e;
		r.unterminated = u;
		return r;
	endfunction

	// apb register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'(REG_SYNTAX_MODE));
	assign prdata = (paddr[2] == 1'(REG_SYNTAX_MODE)) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GNU;
		end else if (cfg_wr) begin
			mode_q <= pwdata[0];
		end
	end

	// handshakes
	assign pop        = tok_valid & ~tok_stall;
	assign cnt_after  = cnt_q - {2'd0, pop};
	assign fire       = valid_s1 & (cnt_after <= 3'd2);
	assign byte_stall = valid_s1 & ~fire;
	assign tok_valid  = cnt_q != 3'd0;
	assign tok_beat   = q_q[head_q];
	assign c          = beat_s1.char_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			beat_s1 <= byte_beat;
		end
	end

	// token step
	always_comb begin
		nx_inside = inside_q;
		nx_dq     = dq_q;
		nx_sq     = sq_q;
		nx_esc    = esc_q;
		nx_cqp    = cqp_q;
		nx_run    = run_q;
		nx_ovf    = ovf_q;
		res[0]    = '0;
		res[1]    = '0;
		n_res     = 2'd0;
		done      = 1'b0;

		if (beat_s1.action == ACT_END) begin
			if (mode_q == MODE_WIN) begin
				if (cqp_q) nx_dq = 1'b0;
				if (run_q != 8'd0) begin
					res[n_res[0]] = mk(CH_BSL, run_q, 1'b0, 1'b0);
					n_res = n_res + 2'd1;
				end
				res[n_res[0]] = mk(8'd0, 8'd0, inside_q, nx_dq);
			end else begin
				if (esc_q) begin
					res[n_res[0]] = mk(CH_BSL, 8'd1, 1'b0, 1'b0);
					n_res = n_res + 2'd1;
				end
				res[n_res[0]] = mk(8'd0, 8'd0, inside_q, dq_q | sq_q);
			end
			n_res     = n_res + 2'd1;
			nx_inside = 1'b0;
			nx_dq     = 1'b0;
			nx_sq     = 1'b0;
			nx_esc    = 1'b0;
			nx_cqp    = 1'b0;
			nx_run    = 8'd0;
		end else if (mode_q == MODE_WIN) begin
			if (cqp_q) begin
				nx_cqp = 1'b0;
				if (c == CH_DQ) begin
					res[0]    = mk(CH_DQ, 8'd1, 1'b0, 1'b0);
					n_res     = 2'd1;
					nx_inside = 1'b1;
					done      = 1'b1;
				end else begin
					nx_dq = 1'b0;
				end
			end
			if (!done && c == CH_BSL) begin
				nx_inside = 1'b1;
				if (run_q < RUN_LIMIT) nx_run = run_q + 8'd1;
				else nx_ovf = 1'b1;
				done = 1'b1;
			end
			if (!done && run_q != 8'd0) begin
				nx_run = 8'd0;
				if (c == CH_DQ) begin
					if (run_q[7:1] != 7'd0) begin
						res[0] = mk(CH_BSL, {1'b0, run_q[7:1]}, 1'b0, 1'b0);
						n_res  = 2'd1;
					end
					if (run_q[0]) begin
						res[n_res[0]] = mk(CH_DQ, 8'd1, 1'b0, 1'b0);
						n_res = n_res + 2'd1;
						done  = 1'b1;
					end
				end else begin
					res[0] = mk(CH_BSL, run_q, 1'b0, 1'b0);
					n_res  = 2'd1;
				end
			end
			if (!done) begin
				if (c == CH_DQ) begin
					if (nx_dq) nx_cqp = 1'b1;
					else nx_dq = 1'b1;
					nx_inside = 1'b1;
				end else if (!nx_dq && is_space(c)) begin
					if (inside_q) begin
						res[n_res[0]] = mk(8'd0, 8'd0, 1'b1, 1'b0);
						n_res = n_res + 2'd1;
					end
					nx_inside = 1'b0;
				end else begin
					res[n_res[0]] = mk(c, 8'd1, 1'b0, 1'b0);
					n_res     = n_res + 2'd1;
					nx_inside = 1'b1;
				end
			end
		end else begin
			if (sq_q) begin
				if (c == CH_SQ) nx_sq = 1'b0;
				else begin
					res[0] = mk(c, 8'd1, 1'b0, 1'b0);
					n_res  = 2'd1;
				end
			end else if (dq_q) begin
				if (esc_q) begin
					res[0] = mk(c, 8'd1, 1'b0, 1'b0);
					n_res  = 2'd1;
					nx_esc = 1'b0;
				end else if (c == CH_DQ) begin
					nx_dq = 1'b0;
				end else if (c == CH_BSL) begin
					nx_esc = 1'b1;
				end else begin
					res[0] = mk(c, 8'd1, 1'b0, 1'b0);
					n_res  = 2'd1;
				end
			end else if (esc_q) begin
				res[0]    = mk(c, 8'd1, 1'b0, 1'b0);
				n_res     = 2'd1;
				nx_esc    = 1'b0;
				nx_inside = 1'b1;
			end else if (c == CH_BSL) begin
				nx_esc    = 1'b1;
				nx_inside = 1'b1;
			end else if (is_space(c)) begin
				if (inside_q) begin
					res[0] = mk(8'd0, 8'd0, 1'b1, 1'b0);
					n_res  = 2'd1;
				end
				nx_inside = 1'b0;
			end else if (c == CH_DQ) begin
				nx_dq     = 1'b1;
				nx_inside = 1'b1;
			end else if (c == CH_SQ) begin
				nx_sq     = 1'b1;
				nx_inside = 1'b1;
			end else begin
				res[0]    = mk(c, 8'd1, 1'b0, 1'b0);
				n_res     = 2'd1;
				nx_inside = 1'b1;
			end
		end

		res[0].run_overflow = nx_ovf;
		res[1].run_overflow = nx_ovf;
		if (n_res == 2'd1) res[0].last = 1'b1;
		if (n_res == 2'd2) res[1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			dq_q     <= 1'b0;
			sq_q     <= 1'b0;
			esc_q    <= 1'b0;
			cqp_q    <= 1'b0;
			run_q    <= 8'd0;
			ovf_q    <= 1'b0;
		end else if (fire) begin
			inside_q <= nx_inside;
			dq_q     <= nx_dq;
			sq_q     <= nx_sq;
			esc_q    <= nx_esc;
			cqp_q    <= nx_cqp;
			run_q    <= nx_run;
			ovf_q    <= nx_ovf;
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 2'd0;
			tail_q <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			if (pop) head_q <= head_q + 2'd1;
			if (fire) begin
				tail_q <= tail_q + n_res;
				cnt_q  <= cnt_after + {1'b0, n_res};
			end else begin
				cnt_q  <= cnt_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && n_res != 2'd0) q_q[tail_q] <= res[0];
		if (fire && n_res == 2'd2) q_q[tail_q + 2'd1] <= res[1];
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(QDEPTH))
		else $error("result queue count out of range");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat_s1.action == ACT_END |-> n_res != 2'd0)
		else $error("end of line gave no result");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat_s1.action == ACT_END |=> !inside_q && !dq_q && !sq_q && !esc_q
			&& !cqp_q && run_q == 8'd0)
		else $error("line state not cleared after end of line");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag dropped");

endmodule
